[rtl/mpc_pkg.sv]
package mpc_pkg;

   // Operation codes carried by req_operation.
   localparam logic [2:0] OP_WRITE_MOUNT = 3'd0;
   localparam logic [2:0] OP_SET_VALID   = 3'd1;
   localparam logic [2:0] OP_PATH_BYTE   = 3'd2;
   localparam logic [2:0] OP_READ_COUNT  = 3'd3;
   localparam logic [2:0] OP_CLEAR_COUNT = 3'd4;

   // Result kinds carried by rsp_result_kind.
   localparam logic KIND_READ_ANSWER = 1'b0;
   localparam logic KIND_PATH_REPORT = 1'b1;

   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [7:0] NUL_CHAR   = 8'h00;

   localparam int MASK_BITS  = 30;
   localparam int COUNT_BITS = 32;

   // Outcome of comparing one mount byte against one path byte.
   typedef struct packed {
      logic drop;   // entry leaves the set still being compared
      logic hit;    // entry's mount point ended at a path boundary
   } cmp_out_type;

endpackage

[rtl/mount_prefix_hit_counter.sv]
// Mount point prefix hit counter.
// One input channel (req_*) carries commands: write a mount byte, set an entry's
// valid mark, feed one path byte, read a counter, clear a counter. Path bytes
// arrive in order; req_last_byte marks the end of a path. The result channel
// (rsp_*) returns a counter read answer, or a path report with one mask bit per
// entry whose counter was incremented by that path.
// Mount writes, valid updates and counter clears complete while the sequencer
// stays idle. A counter read passes through the read state, which captures the
// counter memory output, and the result state, which loads the output register
// and frees the input. Each path byte of a path still being compared runs one
// pass of the shared byte comparator over all entries, reading the mount table
// memory once per entry; a byte that rejects the path or comes after its end
// runs none. The last byte of a path can take up to two compare passes plus one
// counter update pass through the counter memory; the result state then
// presents its report and frees the input.
// req_ready is high only while the sequencer is idle.
// Reset clears valid marks, counters and the path state; mount bytes are not
// cleared and must be written before use. A stalled receiver holds the result
// in the output register; commands without results are still taken meanwhile,
// and a command that produces a result waits until the register frees up.
module mount_prefix_hit_counter import mpc_pkg::*; #(
   parameter int TABLE_ENTRIES = 30,
   parameter int STRING_BYTES  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [4:0]  req_entry,
   input  logic [5:0]  req_position,
   input  logic [7:0]  req_byte_value,
   input  logic        req_valid_flag,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_hit_count,
   output logic [29:0] rsp_match_mask
);

   localparam int EW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int MD  = TABLE_ENTRIES * STRING_BYTES;
   localparam int MAW = (MD > 1) ? $clog2(MD) : 1;
   localparam int PW  = $clog2(STRING_BYTES + 1);
   localparam int MW  = (TABLE_ENTRIES > MASK_BITS) ? TABLE_ENTRIES : MASK_BITS;
   localparam logic [EW-1:0] LAST_IDX = EW'(TABLE_ENTRIES - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CMP  = 3'd1;
   localparam logic [2:0] ST_CNT  = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [EW-1:0]            idx_ff, idx_in;
   logic                     issue_done_ff, issue_done_in;
   logic                     stage_valid_ff, stage_valid_in;
   logic [EW-1:0]            stage_idx_ff, stage_idx_in;
   logic                     last_ff, last_in;
   logic [7:0]               cur_c_ff, cur_c_in;
   logic [TABLE_ENTRIES-1:0] still_ff, still_in;
   logic [TABLE_ENTRIES-1:0] matched_ff, matched_in;
   logic [PW-1:0]            pos_ff, pos_in;
   logic                     rejected_ff, rejected_in;
   logic [TABLE_ENTRIES-1:0] entry_valid_ff, entry_valid_in;
   logic [TABLE_ENTRIES-1:0] cnt_valid_ff, cnt_valid_in;
   logic                     rd_ok_ff, rd_ok_in;
   logic [EW-1:0]            rd_idx_ff, rd_idx_in;
   logic                     res_kind_ff, res_kind_in;
   logic [31:0]              res_hit_ff, res_hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [31:0]              rsp_hit_ff, rsp_hit_in;
   logic [29:0]              rsp_mask_ff, rsp_mask_in;

   logic                     mnt_we;
   logic [MAW-1:0]           mnt_waddr;
   logic [MAW-1:0]           mnt_raddr;
   logic [7:0]               mnt_rdata;
   logic                     cnt_we;
   logic [EW-1:0]            cnt_waddr;
   logic [31:0]              cnt_wdata;
   logic [EW-1:0]            cnt_raddr;
   logic [31:0]              cnt_rdata;
   cmp_out_type              cmp_out;

   logic                     accept;
   logic                     entry_ok;
   logic                     pos_ok;
   logic [EW-1:0]            req_idx;
   logic                     path_active;
   logic [7:0]               eff_c;
   logic [PW-1:0]            pos_next;
   logic [MW-1:0]            hit_wide;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign entry_ok  = (32'(req_entry) < TABLE_ENTRIES);
   assign pos_ok    = (32'(req_position) < STRING_BYTES);
   assign req_idx   = EW'(req_entry);

   assign path_active = !rejected_ff && (pos_ff < PW'(STRING_BYTES));
   assign eff_c       = (pos_ff >= PW'(STRING_BYTES - 1)) ? NUL_CHAR : req_byte_value;
   assign pos_next    = (cur_c_ff == NUL_CHAR) ? PW'(STRING_BYTES) : PW'(pos_ff + PW'(1));
   assign hit_wide    = MW'(matched_ff & entry_valid_ff);

   assign mnt_we    = accept && (req_operation == OP_WRITE_MOUNT) && entry_ok && pos_ok;
   assign mnt_waddr = MAW'(32'(req_entry) * STRING_BYTES + 32'(req_position));
   assign mnt_raddr = MAW'(32'(idx_ff) * STRING_BYTES + 32'(pos_ff));
   assign cnt_raddr = (state_ff == ST_IDLE) ? req_idx : idx_ff;

   mpc_ram #(
      .WIDTH (8),
      .DEPTH (MD)
   ) u_mount_ram (
      .clock   (clock),
      .wr_en   (mnt_we),
      .wr_addr (mnt_waddr),
      .wr_data (req_byte_value),
      .rd_addr (mnt_raddr),
      .rd_data (mnt_rdata)
   );

   mpc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   mpc_match_unit u_match (
      .mount_byte (mnt_rdata),
      .path_byte  (cur_c_ff),
      .pos_first  (pos_ff == PW'(0)),
      .pos_second (pos_ff == PW'(1)),
      .result     (cmp_out)
   );

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      issue_done_in  = issue_done_ff;
      stage_valid_in = 1'b0;
      stage_idx_in   = stage_idx_ff;
      last_in        = last_ff;
      cur_c_in       = cur_c_ff;
      still_in       = still_ff;
      matched_in     = matched_ff;
      pos_in         = pos_ff;
      rejected_in    = rejected_ff;
      entry_valid_in = entry_valid_ff;
      cnt_valid_in   = cnt_valid_ff;
      rd_ok_in       = rd_ok_ff;
      rd_idx_in      = rd_idx_ff;
      res_kind_in    = res_kind_ff;
      res_hit_in     = res_hit_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_hit_in     = rsp_hit_ff;
      rsp_mask_in    = rsp_mask_ff;
      cnt_we         = 1'b0;
      cnt_waddr      = stage_idx_ff;
      cnt_wdata      = (cnt_valid_ff[stage_idx_ff] ? cnt_rdata : 32'd0) + 32'd1;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Issue side of the pass: one memory read per entry, compared in the next cycle.
      if ((state_ff == ST_CMP || state_ff == ST_CNT) && !issue_done_ff) begin
         stage_valid_in = 1'b1;
         stage_idx_in   = idx_ff;
         if (idx_ff == LAST_IDX) begin
            issue_done_in = 1'b1;
         end else begin
            idx_in = idx_ff + EW'(1);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  OP_WRITE_MOUNT: begin
                  end
                  OP_SET_VALID: begin
                     if (entry_ok) begin
                        entry_valid_in[req_idx] = req_valid_flag;
                     end
                  end
                  OP_PATH_BYTE: begin
                     last_in       = req_last_byte;
                     idx_in        = '0;
                     issue_done_in = 1'b0;
                     res_kind_in   = KIND_PATH_REPORT;
                     res_hit_in    = 32'd0;
                     if (path_active) begin
                        if (pos_ff == PW'(0) && eff_c != SLASH_CHAR) begin
                           rejected_in = 1'b1;
                           if (req_last_byte) begin
                              state_in = ST_DONE;
                           end
                        end else begin
                           cur_c_in = eff_c;
                           state_in = ST_CMP;
                        end
                     end else if (req_last_byte) begin
                        state_in = rejected_ff ? ST_DONE : ST_CNT;
                     end
                  end
                  OP_READ_COUNT: begin
                     rd_ok_in  = entry_ok;
                     rd_idx_in = req_idx;
                     state_in  = ST_READ;
                  end
                  OP_CLEAR_COUNT: begin
                     if (entry_ok) begin
                        cnt_valid_in[req_idx] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CMP: begin
            if (stage_valid_ff) begin
               if (still_ff[stage_idx_ff]) begin
                  if (cmp_out.hit) begin
                     matched_in[stage_idx_ff] = 1'b1;
                  end
                  if (cmp_out.drop) begin
                     still_in[stage_idx_ff] = 1'b0;
                  end
               end
               if (stage_idx_ff == LAST_IDX) begin
                  pos_in        = pos_next;
                  idx_in        = '0;
                  issue_done_in = 1'b0;
                  if (!last_ff) begin
                     state_in = ST_IDLE;
                  end else if (pos_next < PW'(STRING_BYTES)) begin
                     // The path ended on a nonzero byte: compare the implied terminator.
                     cur_c_in = NUL_CHAR;
                  end else begin
                     state_in = ST_CNT;
                  end
               end
            end
         end
         ST_CNT: begin
            if (stage_valid_ff) begin
               if (matched_ff[stage_idx_ff] && entry_valid_ff[stage_idx_ff]) begin
                  cnt_we                     = 1'b1;
                  cnt_valid_in[stage_idx_ff] = 1'b1;
               end
               if (stage_idx_ff == LAST_IDX) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            res_kind_in = KIND_READ_ANSWER;
            res_hit_in  = (rd_ok_ff && cnt_valid_ff[rd_idx_ff]) ? cnt_rdata : 32'd0;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_hit_in   = res_hit_ff;
               rsp_mask_in  = '0;
               state_in     = ST_IDLE;
               if (res_kind_ff == KIND_PATH_REPORT) begin
                  rsp_mask_in = hit_wide[29:0];
                  still_in    = '1;
                  matched_in  = '0;
                  pos_in      = '0;
                  rejected_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         issue_done_ff  <= 1'b0;
         stage_valid_ff <= 1'b0;
         still_ff       <= '1;
         matched_ff     <= '0;
         pos_ff         <= '0;
         rejected_ff    <= 1'b0;
         entry_valid_ff <= '0;
         cnt_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idx_ff         <= idx_in;
         issue_done_ff  <= issue_done_in;
         stage_valid_ff <= stage_valid_in;
         still_ff       <= still_in;
         matched_ff     <= matched_in;
         pos_ff         <= pos_in;
         rejected_ff    <= rejected_in;
         entry_valid_ff <= entry_valid_in;
         cnt_valid_ff   <= cnt_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      stage_idx_ff <= stage_idx_in;
      last_ff      <= last_in;
      cur_c_ff     <= cur_c_in;
      rd_ok_ff     <= rd_ok_in;
      rd_idx_ff    <= rd_idx_in;
      res_kind_ff  <= res_kind_in;
      res_hit_ff   <= res_hit_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_hit_count   = rsp_hit_ff;
   assign rsp_match_mask  = rsp_mask_ff;

   // An entry that has matched is never still under comparison.
   a_match_excludes_still: assert property (@(posedge clock) disable iff (reset)
      (matched_ff & still_ff) == '0)
      else $error("matched entry still marked as comparing");

   // A rejected path never accumulates matches.
   a_rejected_no_match: assert property (@(posedge clock) disable iff (reset)
      rejected_ff |-> (matched_ff == '0))
      else $error("rejected path holds matches");

   // The path position never runs past the end marker.
   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PW'(STRING_BYTES))
      else $error("path position out of range");

   // A new result only comes out of the sequencer's result state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |-> $past(state_ff == ST_DONE))
      else $error("result produced outside result state");

   // Counter updates happen only during the counter pass.
   a_cnt_write_in_pass: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (state_ff == ST_CNT) && stage_valid_ff)
      else $error("counter written outside update pass");

endmodule

[rtl/mpc_ram.sv]
module mpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mpc_match_unit.sv]
module mpc_match_unit import mpc_pkg::*; (
   input  logic [7:0]  mount_byte,
   input  logic [7:0]  path_byte,
   input  logic        pos_first,
   input  logic        pos_second,
   output cmp_out_type result
);

   logic mount_end;

   assign mount_end = (mount_byte == NUL_CHAR);

   // A mount point that ends here matches only if it was non-empty and the path
   // is at a component boundary. A one-byte mount matches on its first byte alone.
   assign result.hit  = mount_end && !pos_first &&
                        (pos_second || path_byte == SLASH_CHAR || path_byte == NUL_CHAR);
   assign result.drop = mount_end || (path_byte != mount_byte);

endmodule
